// ----- src/scd_pkg.sv -----
// Shared types, constants and character tables for the set-1 scan code decoder.
// No dependencies.
`timescale 1ns / 1ps

package scd_pkg;

  localparam int unsigned CodeW     = 8;
  localparam int unsigned CharW     = 7;
  localparam int unsigned FlagDepth = 2;
  localparam int unsigned FlagAw    = $clog2(FlagDepth);

  localparam logic [FlagAw-1:0] FLAG_ADDR = '0;

  localparam logic [CodeW-1:0] CODE_PREFIX = 8'hE0;
  localparam logic [CodeW-1:0] CODE_BREAK  = 8'h80;
  localparam logic [6:0]       KEY_CTRL    = 7'h1D;
  localparam logic [6:0]       KEY_ALT     = 7'h38;
  localparam logic [6:0]       KEY_LSHIFT  = 7'h2A;
  localparam logic [6:0]       KEY_RSHIFT  = 7'h36;
  localparam logic [6:0]       KEY_CAPS    = 7'h3A;
  localparam logic [CodeW-1:0] CODE_ENTER  = 8'h1C;
  localparam logic [CodeW-1:0] CODE_LIMIT  = 8'h3A;

  localparam logic [CharW-1:0] CHAR_CR = 7'h0D;
  localparam logic [CharW-1:0] CHAR_LF = 7'h0A;

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;

  typedef struct packed {
    logic shift;
    logic ctrl;
    logic alt;
    logic caps;
  } flags_t;

  localparam int unsigned FlagW = $bits(flags_t);

  typedef struct packed {
    flags_t           flags;
    logic [1:0]       cnt;
    logic [CharW-1:0] ch;
  } dec_t;

  function automatic logic is_letter(input logic [CodeW-1:0] c);
    return (c >= 8'h10 && c <= 8'h19) || (c >= 8'h1E && c <= 8'h26) ||
           (c >= 8'h2C && c <= 8'h32);
  endfunction

  function automatic logic [CharW-1:0] plain_char(input logic [5:0] c);
    logic [CharW-1:0] r;
    r = 7'h00;
    case (c)
      6'h01: r = 7'h1B; 6'h02: r = 7'h31; 6'h03: r = 7'h32; 6'h04: r = 7'h33;
      6'h05: r = 7'h34; 6'h06: r = 7'h35; 6'h07: r = 7'h36; 6'h08: r = 7'h37;
      6'h09: r = 7'h38; 6'h0A: r = 7'h39; 6'h0B: r = 7'h30; 6'h0C: r = 7'h2D;
      6'h0D: r = 7'h3D; 6'h0E: r = 7'h08; 6'h0F: r = 7'h09; 6'h10: r = 7'h71;
      6'h11: r = 7'h77; 6'h12: r = 7'h65; 6'h13: r = 7'h72; 6'h14: r = 7'h74;
      6'h15: r = 7'h79; 6'h16: r = 7'h75; 6'h17: r = 7'h69; 6'h18: r = 7'h6F;
      6'h19: r = 7'h70; 6'h1A: r = 7'h5B; 6'h1B: r = 7'h5D; 6'h1C: r = 7'h0D;
      6'h1E: r = 7'h61; 6'h1F: r = 7'h73; 6'h20: r = 7'h64; 6'h21: r = 7'h66;
      6'h22: r = 7'h67; 6'h23: r = 7'h68; 6'h24: r = 7'h6A; 6'h25: r = 7'h6B;
      6'h26: r = 7'h6C; 6'h27: r = 7'h3B; 6'h28: r = 7'h27; 6'h29: r = 7'h60;
      6'h2B: r = 7'h5C; 6'h2C: r = 7'h7A; 6'h2D: r = 7'h78; 6'h2E: r = 7'h63;
      6'h2F: r = 7'h76; 6'h30: r = 7'h62; 6'h31: r = 7'h6E; 6'h32: r = 7'h6D;
      6'h33: r = 7'h2C; 6'h34: r = 7'h2E; 6'h35: r = 7'h2F; 6'h37: r = 7'h2A;
      6'h39: r = 7'h20;
      default: r = 7'h00;
    endcase
    return r;
  endfunction

  function automatic logic [CharW-1:0] shift_char(input logic [CodeW-1:0] c);
    logic [CharW-1:0] r;
    r = plain_char(c[5:0]);
    if (is_letter(c)) begin
      r = r - 7'h20;
    end else begin
      case (c[5:0])
        6'h02: r = 7'h21; 6'h03: r = 7'h40; 6'h04: r = 7'h23; 6'h05: r = 7'h24;
        6'h06: r = 7'h25; 6'h07: r = 7'h5E; 6'h08: r = 7'h26; 6'h09: r = 7'h2A;
        6'h0A: r = 7'h28; 6'h0B: r = 7'h29; 6'h0C: r = 7'h5F; 6'h0D: r = 7'h2B;
        6'h1A: r = 7'h7B; 6'h1B: r = 7'h7D; 6'h27: r = 7'h3A; 6'h28: r = 7'h22;
        6'h29: r = 7'h7E; 6'h2B: r = 7'h7C; 6'h33: r = 7'h3C; 6'h34: r = 7'h3E;
        6'h35: r = 7'h3F;
        default: r = plain_char(c[5:0]);
      endcase
    end
    return r;
  endfunction

endpackage

// ----- src/scd_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module scd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/scd_decode.sv -----
// Decodes one scan byte against the current modifier flags.
// Depends on scd_pkg.
`timescale 1ns / 1ps

module scd_decode (
  input  logic [scd_pkg::CodeW-1:0] code,
  input  scd_pkg::flags_t           flags_cur,
  output scd_pkg::dec_t             dec
);

  logic [6:0] key;
  logic       make;
  logic       upper;

  assign key  = code[6:0];
  assign make = ~code[7];

  always_comb begin
    dec       = '0;
    dec.flags = flags_cur;
    dec.cnt   = scd_pkg::CNT_NONE;
    upper     = scd_pkg::is_letter(code) ? (flags_cur.caps ^ flags_cur.shift)
                                         : flags_cur.shift;
    dec.ch    = upper ? scd_pkg::shift_char(code) : scd_pkg::plain_char(code[5:0]);
    if (code == scd_pkg::CODE_PREFIX) begin
      dec.cnt = scd_pkg::CNT_NONE;
    end else if (key == scd_pkg::KEY_CTRL) begin
      dec.flags.ctrl = make;
    end else if (key == scd_pkg::KEY_ALT) begin
      dec.flags.alt = make;
    end else if (key == scd_pkg::KEY_LSHIFT || key == scd_pkg::KEY_RSHIFT) begin
      dec.flags.shift = make;
    end else if (key == scd_pkg::KEY_CAPS) begin
      dec.flags.caps = flags_cur.caps ^ ~make;
    end else if (code == scd_pkg::CODE_ENTER) begin
      dec.cnt = scd_pkg::CNT_TWO;
    end else if (code <= scd_pkg::CODE_LIMIT) begin
      dec.cnt = scd_pkg::CNT_ONE;
    end
  end

endmodule

// ----- src/scan_code_set1_to_ascii.sv -----
// Set-1 scan code to ASCII decoder: top level with flag RAM, decode stage and output register.
// Depends on scd_pkg, scd_ram and scd_decode.
// An accepted byte is registered in the decode stage; its results go to the output register.
// Throughput: one byte per cycle unless the output stalls; an enter byte stays for CR and LF.
// The decode stage, fed by the registered flag RAM read, sets the rate.
// Reset clears all control state; the flags read as zero until the first flag RAM write.
`timescale 1ns / 1ps

module scan_code_set1_to_ascii (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [scd_pkg::CodeW-1:0] in_scan_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [scd_pkg::CharW-1:0] out_char_code,
  output logic                      out_ctrl_held,
  output logic                      out_alt_held,
  output logic                      out_last
);

  logic                      p_valid_r, p_valid_nxt;
  logic                      p_phase_r, p_phase_nxt;
  logic [scd_pkg::CodeW-1:0] p_code_r;
  logic                      fwd_r;
  scd_pkg::flags_t           fwd_data_r;
  logic                      vld_r;
  logic                      out_valid_r, out_valid_nxt;
  logic [scd_pkg::CharW-1:0] out_char_r;
  logic                      out_ctrl_r, out_alt_r, out_last_r;

  logic                      rd_en, wr_en, push, p_done, out_free;
  logic [scd_pkg::FlagW-1:0] rd_data;
  scd_pkg::flags_t           flags_cur;
  scd_pkg::dec_t             dec;
  logic [scd_pkg::CharW-1:0] push_char;
  logic                      push_last;

  scd_ram #(
    .WIDTH(scd_pkg::FlagW),
    .DEPTH(scd_pkg::FlagDepth)
  ) u_flags (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (scd_pkg::FLAG_ADDR),
    .wr_data (dec.flags),
    .rd_en   (rd_en),
    .rd_addr (scd_pkg::FLAG_ADDR),
    .rd_data (rd_data)
  );

  always_comb begin
    if (fwd_r) begin
      flags_cur = fwd_data_r;
    end else if (vld_r) begin
      flags_cur = scd_pkg::flags_t'(rd_data);
    end else begin
      flags_cur = '0;
    end
  end

  scd_decode u_decode (
    .code      (p_code_r),
    .flags_cur (flags_cur),
    .dec       (dec)
  );

  assign out_free  = ~out_valid_r | out_ready;
  assign push      = p_valid_r && dec.cnt != scd_pkg::CNT_NONE && out_free;
  assign push_last = !(dec.cnt == scd_pkg::CNT_TWO && !p_phase_r);
  assign p_done    = p_valid_r && (dec.cnt == scd_pkg::CNT_NONE || (push && push_last));
  assign in_ready  = ~p_valid_r | p_done;
  assign rd_en     = in_valid & in_ready;
  assign wr_en     = p_done;

  always_comb begin
    if (dec.cnt == scd_pkg::CNT_TWO) begin
      push_char = p_phase_r ? scd_pkg::CHAR_LF : scd_pkg::CHAR_CR;
    end else begin
      push_char = dec.ch;
    end
  end

  always_comb begin
    p_valid_nxt = p_valid_r;
    p_phase_nxt = p_phase_r;
    if (p_done) begin
      p_valid_nxt = 1'b0;
      p_phase_nxt = 1'b0;
    end else if (push) begin
      p_phase_nxt = 1'b1;
    end
    if (rd_en) begin
      p_valid_nxt = 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (push) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r   <= 1'b0;
      p_phase_r   <= 1'b0;
      fwd_r       <= 1'b0;
      vld_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p_valid_r   <= p_valid_nxt;
      p_phase_r   <= p_phase_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_en) begin
        vld_r <= 1'b1;
      end
      if (rd_en) begin
        fwd_r <= wr_en;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      p_code_r   <= in_scan_byte;
      fwd_data_r <= dec.flags;
    end
    if (push) begin
      out_char_r <= push_char;
      out_ctrl_r <= dec.flags.ctrl;
      out_alt_r  <= dec.flags.alt;
      out_last_r <= push_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_ctrl_held = out_ctrl_r;
  assign out_alt_held  = out_alt_r;
  assign out_last      = out_last_r;

  a_phase_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    p_phase_r |-> p_valid_r)
    else $error("phase set with no item in decode stage");

  a_cr_pending_lf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (p_valid_r && p_phase_r))
    else $error("CR shown without LF pending");

  a_cr_char: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (out_char_r == scd_pkg::CHAR_CR))
    else $error("non-final result is not CR");

  a_write_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> vld_r)
    else $error("flag entry not marked after write");

  a_no_ready_mid_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (p_valid_r && dec.cnt == scd_pkg::CNT_TWO && !p_phase_r) |-> !in_ready)
    else $error("input taken before enter run complete");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for scan_code_set1_to_ascii: directed table, then random key sequences.
// Depends on scd_pkg and the decoder RTL; holds its own keyboard-state predictor.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned NumItems   = 1600;
  localparam int unsigned CalmItems  = 150;
  localparam int unsigned HoldCycles = 160;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned NumDir     = 26;

  typedef struct packed {
    logic [scd_pkg::CharW-1:0] ch;
    logic                      ctrl;
    logic                      alt;
    logic                      last;
  } char_exp_t;

  typedef struct packed {
    logic [scd_pkg::CodeW-1:0] code;
    logic                      typed;
    logic [1:0]                n;
    logic [scd_pkg::CharW-1:0] c0;
    logic [scd_pkg::CharW-1:0] c1;
  } dir_row_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic [scd_pkg::CodeW-1:0] in_scan_byte;
  logic                      out_valid;
  logic                      out_ready;
  logic [scd_pkg::CharW-1:0] out_char_code;
  logic                      out_ctrl_held;
  logic                      out_alt_held;
  logic                      out_last;

  char_exp_t                 char_q[$];
  scd_pkg::flags_t           mods;
  logic [scd_pkg::CharW-1:0] plain_tab [59];
  logic [scd_pkg::CharW-1:0] shift_tab [59];
  dir_row_t                  dir_tab [NumDir];

  int unsigned err_cnt;
  int unsigned chk_cnt;
  int unsigned sent_cnt;
  int unsigned enter_cnt;
  int unsigned caps_cnt;
  int unsigned cyc_cnt;
  int unsigned quiet_left;
  bit          calm;
  bit          hold_req;

  scan_code_set1_to_ascii u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_scan_byte  (in_scan_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char_code (out_char_code),
    .out_ctrl_held (out_ctrl_held),
    .out_alt_held  (out_alt_held),
    .out_last      (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cyc_cnt, char_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_cnt < 40) begin
      $display("%0t ns: %s got %0h want %0h", $time, what, got, want);
    end
    err_cnt++;
  endtask

  function automatic logic in_alpha_range(input logic [scd_pkg::CodeW-1:0] c);
    return (c >= 8'h10 && c <= 8'h19) || (c >= 8'h1E && c <= 8'h26) ||
           (c >= 8'h2C && c <= 8'h32);
  endfunction

  // Update the modifier flags and work out the characters one byte gives.
  task automatic predict_scan(input logic [scd_pkg::CodeW-1:0] code, output int n,
                              output char_exp_t r0, output char_exp_t r1);
    logic [6:0] key;
    logic       make;
    logic       upper;
    key  = code[6:0];
    make = ~code[7];
    n    = 0;
    r0   = '0;
    r1   = '0;
    if (code == scd_pkg::CODE_PREFIX) begin
      n = 0;
    end else if (key == scd_pkg::KEY_CTRL) begin
      mods.ctrl = make;
    end else if (key == scd_pkg::KEY_ALT) begin
      mods.alt = make;
    end else if (key == scd_pkg::KEY_LSHIFT || key == scd_pkg::KEY_RSHIFT) begin
      mods.shift = make;
    end else if (key == scd_pkg::KEY_CAPS) begin
      if (!make) begin
        mods.caps = ~mods.caps;
        caps_cnt++;
      end
    end else if (code == scd_pkg::CODE_ENTER) begin
      r0 = '{ch: scd_pkg::CHAR_CR, ctrl: mods.ctrl, alt: mods.alt, last: 1'b0};
      r1 = '{ch: scd_pkg::CHAR_LF, ctrl: mods.ctrl, alt: mods.alt, last: 1'b1};
      n  = 2;
      enter_cnt++;
    end else if (code <= scd_pkg::CODE_LIMIT) begin
      upper = in_alpha_range(code) ? (mods.caps ^ mods.shift) : mods.shift;
      r0.ch   = upper ? shift_tab[code[5:0]] : plain_tab[code[5:0]];
      r0.ctrl = mods.ctrl;
      r0.alt  = mods.alt;
      r0.last = 1'b1;
      n       = 1;
    end
  endtask

  // Offer one byte, hold it until the transfer, then queue what it should give.
  task automatic offer_scan(input logic [scd_pkg::CodeW-1:0] code, input logic typed,
                            input logic [1:0] n_t, input logic [scd_pkg::CharW-1:0] c0,
                            input logic [scd_pkg::CharW-1:0] c1);
    int        n;
    char_exp_t r0;
    char_exp_t r1;
    in_valid     <= 1'b1;
    in_scan_byte <= code;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_scan(code, n, r0, r1);
    if (typed) begin
      if (n != int'(n_t)) begin
        report_mismatch("result count of directed row", n, int'(n_t));
      end
      r0.ch = c0;
      r1.ch = c1;
    end
    if (n > 0) char_q.push_back(r0);
    if (n > 1) char_q.push_back(r1);
    sent_cnt++;
  endtask

  task automatic send_byte(input logic [scd_pkg::CodeW-1:0] code);
    if (calm || quiet_left > 0) begin
      if (quiet_left > 0) quiet_left--;
    end else if ($urandom_range(0, 49) == 0) begin
      quiet_left = $urandom_range(10, 40);
    end else if ($urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    offer_scan(code, 1'b0, 2'd0, '0, '0);
  endtask

  function automatic logic [scd_pkg::CodeW-1:0] pick_key();
    logic [scd_pkg::CodeW-1:0] k;
    k = 8'($urandom_range(0, 8'h39));
    while (k[6:0] == scd_pkg::KEY_CTRL || k[6:0] == scd_pkg::KEY_ALT ||
           k[6:0] == scd_pkg::KEY_LSHIFT || k[6:0] == scd_pkg::KEY_RSHIFT) begin
      k = 8'($urandom_range(0, 8'h39));
    end
    return k;
  endfunction

  task automatic typing_sequence();
    int                        sel;
    int                        cnt;
    logic [scd_pkg::CodeW-1:0] k;
    logic [scd_pkg::CodeW-1:0] m;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      k = pick_key();
      send_byte(k);
      if ($urandom_range(0, 9) < 7) send_byte(k | scd_pkg::CODE_BREAK);
    end else if (sel < 65) begin
      case ($urandom_range(0, 3))
        0: m = {1'b0, scd_pkg::KEY_CTRL};
        1: m = {1'b0, scd_pkg::KEY_ALT};
        2: m = {1'b0, scd_pkg::KEY_LSHIFT};
        default: m = {1'b0, scd_pkg::KEY_RSHIFT};
      endcase
      send_byte(m);
      cnt = $urandom_range(1, 4);
      repeat (cnt) begin
        k = pick_key();
        send_byte(k);
        send_byte(k | scd_pkg::CODE_BREAK);
      end
      if ($urandom_range(0, 4) != 0) send_byte(m | scd_pkg::CODE_BREAK);
    end else if (sel < 73) begin
      send_byte({1'b0, scd_pkg::KEY_CAPS});
      send_byte({1'b1, scd_pkg::KEY_CAPS});
    end else if (sel < 80) begin
      send_byte(scd_pkg::CODE_ENTER);
      send_byte(scd_pkg::CODE_ENTER | scd_pkg::CODE_BREAK);
    end else if (sel < 87) begin
      k = 8'($urandom_range(0, 8'h7F));
      send_byte(scd_pkg::CODE_PREFIX);
      send_byte(k);
      send_byte(scd_pkg::CODE_PREFIX);
      send_byte(k | scd_pkg::CODE_BREAK);
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (char_q.size() == 0) begin
        report_mismatch("unexpected transfer, char_code", int'(out_char_code), 0);
      end else begin
        if (out_char_code !== char_q[0].ch) begin
          report_mismatch("char_code", int'(out_char_code), int'(char_q[0].ch));
        end
        if (out_ctrl_held !== char_q[0].ctrl) begin
          report_mismatch("ctrl_held", int'(out_ctrl_held), int'(char_q[0].ctrl));
        end
        if (out_alt_held !== char_q[0].alt) begin
          report_mismatch("alt_held", int'(out_alt_held), int'(char_q[0].alt));
        end
        if (out_last !== char_q[0].last) begin
          report_mismatch("last", int'(out_last), int'(char_q[0].last));
        end
        void'(char_q.pop_front());
        chk_cnt++;
      end
    end
  end

  initial begin : rx_side
    int  win;
    bit  noisy;
    bit  hold_seen;
    out_ready <= 1'b0;
    win       = 0;
    noisy     = 1'b1;
    hold_seen = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (win == 0) begin
        win   = 64;
        noisy = ($urandom_range(0, 2) != 0);
      end
      win--;
      if (hold_req && !hold_seen) begin
        hold_seen = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!calm && noisy && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : tx_side
    bit held_done;
    bit pause_done;
    plain_tab = '{
      7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
      7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
      7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0D, 7'h00, 7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68,
      7'h6A, 7'h6B, 7'h6C, 7'h3B, 7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
      7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00
    };
    shift_tab = '{
      7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28, 7'h29,
      7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
      7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0D, 7'h00, 7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48,
      7'h4A, 7'h4B, 7'h4C, 7'h3A, 7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
      7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00
    };
    // code, typed, results, first char, second char
    dir_tab = '{
      '{8'h00, 1'b1, 2'd1, 7'h00,   7'h00},
      '{8'h01, 1'b1, 2'd1, 7'h1B,   7'h00},
      '{8'h0F, 1'b1, 2'd1, 7'h09,   7'h00},
      '{8'h10, 1'b1, 2'd1, 7'h71,   7'h00},
      '{8'h1C, 1'b1, 2'd2, scd_pkg::CHAR_CR, scd_pkg::CHAR_LF},
      '{8'h39, 1'b1, 2'd1, 7'h20,   7'h00},
      '{8'h3A, 1'b1, 2'd0, 7'h00,   7'h00},
      '{8'hBA, 1'b1, 2'd0, 7'h00,   7'h00},
      '{8'h10, 1'b1, 2'd1, 7'h51,   7'h00},
      '{8'h2A, 1'b1, 2'd0, 7'h00,   7'h00},
      '{8'h10, 1'b1, 2'd1, 7'h71,   7'h00},
      '{8'h02, 1'b1, 2'd1, 7'h21,   7'h00},
      '{8'hAA, 1'b1, 2'd0, 7'h00,   7'h00},
      '{8'hBA, 1'b1, 2'd0, 7'h00,   7'h00},
      '{8'h1D, 1'b1, 2'd0, 7'h00,   7'h00},
      '{8'h38, 1'b1, 2'd0, 7'h00,   7'h00},
      '{8'h1E, 1'b1, 2'd1, 7'h61,   7'h00},
      '{8'h9D, 1'b1, 2'd0, 7'h00,   7'h00},
      '{8'hB8, 1'b1, 2'd0, 7'h00,   7'h00},
      '{8'hE0, 1'b1, 2'd0, 7'h00,   7'h00},
      '{8'h3B, 1'b1, 2'd0, 7'h00,   7'h00},
      '{8'hFF, 1'b1, 2'd0, 7'h00,   7'h00},
      '{8'h36, 1'b1, 2'd0, 7'h00,   7'h00},
      '{8'h2C, 1'b1, 2'd1, 7'h5A,   7'h00},
      '{8'hB6, 1'b1, 2'd0, 7'h00,   7'h00},
      '{8'h29, 1'b0, 2'd0, 7'h00,   7'h00}
    };
    mods         = '0;
    sent_cnt     = 0;
    enter_cnt    = 0;
    caps_cnt     = 0;
    quiet_left   = 0;
    calm         = 1'b0;
    hold_req     = 1'b0;
    held_done    = 1'b0;
    pause_done   = 1'b0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_scan_byte <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NumDir; i++) begin
      offer_scan(dir_tab[i].code, dir_tab[i].typed, dir_tab[i].n, dir_tab[i].c0,
                 dir_tab[i].c1);
    end

    while (sent_cnt < NumItems) begin
      if (!held_done && sent_cnt >= 500) begin
        held_done  = 1'b1;
        hold_req   = 1'b1;
        quiet_left = 80;
      end
      if (!pause_done && sent_cnt >= 900) begin
        pause_done = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (char_q.size() != 0) @(posedge clk);
      end
      if (sent_cnt >= NumItems - CalmItems) calm = 1'b1;
      typing_sequence();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (char_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Sent %0d scan bytes, checked %0d characters", sent_cnt, chk_cnt);
    $display("Enter keys %0d, caps lock toggles %0d, mismatches %0d",
             enter_cnt, caps_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/scd_pkg.sv
src/scd_ram.sv
src/scd_decode.sv
src/scan_code_set1_to_ascii.sv
tb/tb_top.sv
